>>> rtl/chji_pkg.sv
package chji_pkg;

  // fraction bits of the normalized time and of the basis weights
  localparam int QBITS = 30;
  // iteration counter width of the divider
  localparam int QCW = $clog2(QBITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_WGT,
    ST_MAC,
    ST_OUT
  } chji_state_e;

endpackage

>>> rtl/chji_div.sv
module chji_div import chji_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          dividend_i,
  input  logic [31:0]          divisor_i,
  output logic                 done_o,
  output logic [QBITS-1:0]     quot_o
);

  // restoring division, one quotient bit per cycle, dividend below divisor
  logic [32:0]      rem_q;
  logic [31:0]      dvs_q;
  logic [QBITS-1:0] quot_q;
  logic [QCW-1:0]   cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q[31:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == QCW'(QBITS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == QCW'(QBITS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i};
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quot_q <= {quot_q[QBITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/cubic_hermite_joint_interpolator.sv
// a load transaction gives no result; a tick registers one result per joint, joint zero first;
// the time divider runs first unless the time is clamped, and output stalls hold the sweep
// throughput: one transaction at a time, set by the serial divider and the one shared multiplier;
// the next transaction is taken once the last joint result is registered
// reset: asynchronous, active low; clears timing, per joint valid bits and handshake state
module cubic_hermite_joint_interpolator import chji_pkg::*; #(
  parameter int NUM_JOINTS = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [2:0]         joint_index_i,
  input  logic signed [31:0] start_pos_i,
  input  logic signed [31:0] start_vel_i,
  input  logic signed [31:0] goal_pos_i,
  input  logic signed [31:0] goal_vel_i,
  input  logic [31:0]        run_time_i,
  input  logic [31:0]        time_now_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_joint_o,
  output logic signed [31:0] position_o,
  output logic               last_o
);

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // ---------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------
  chji_state_e state_q, state_d;

  // per joint segment store: {start_pos, start_vel, goal_pos, goal_vel}
  logic [127:0]          seg_mem [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] vld_q;
  logic [127:0]          rd_q;
  logic                  rd_vld_q;

  logic [31:0] seg_start_q;
  logic [31:0] seg_dur_q;

  logic [QBITS:0]     t_q;
  logic [QBITS:0]     t2_q;
  logic signed [31:0] h_q [4];
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic [2:0]         k_q;
  logic [JW-1:0]      jcnt_q;

  logic               out_valid_q;
  logic [2:0]         out_joint_q;
  logic signed [31:0] position_q;
  logic               last_q;

  // ---------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------
  logic        in_acc;
  logic        load_ok;
  logic        tick_acc;
  logic [32:0] elapsed;
  logic        el_nonpos;
  logic        t_full;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign load_ok  = in_acc && req_type_i && ({2'b00, joint_index_i} < 5'(NUM_JOINTS));
  assign tick_acc = in_acc && !req_type_i;

  // signed 33 bit elapsed time since the segment start
  assign elapsed   = {1'b0, time_now_i} - {1'b0, seg_start_q};
  assign el_nonpos = elapsed[32] || (elapsed == '0);
  // zero duration or reaching the end of the segment clamps t to one
  assign t_full    = (seg_dur_q == '0) || (!elapsed[32] && (elapsed[31:0] >= seg_dur_q));

  // ---------------------------------------------------------------------
  // time divider
  // ---------------------------------------------------------------------
  logic             div_start;
  logic             div_done;
  logic [QBITS-1:0] div_quot;

  chji_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed[31:0]),
    .divisor_i  (seg_dur_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  logic          out_free;
  logic          jlast;
  logic          rd_en;
  logic [JW-1:0] rd_addr;
  logic          out_load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign jlast    = (jcnt_q == JW'(NUM_JOINTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_acc) begin
          state_d = (t_full || el_nonpos) ? ST_SQ : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_SQ;
      end
      ST_SQ:   state_d = ST_CUBE;
      ST_CUBE: state_d = ST_WGT;
      ST_WGT:  state_d = ST_MAC;
      ST_MAC: begin
        if (k_q == 3'd4) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = jlast ? ST_IDLE : ST_MAC;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = tick_acc && !t_full && !el_nonpos;
      end
      ST_WGT: begin
        // fetch joint zero while the weights settle
        rd_en = 1'b1;
      end
      ST_OUT: begin
        out_load = out_free;
        rd_en    = out_free && !jlast;
        rd_addr  = jcnt_q + 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // segment store: write on a load, registered read for the tick sweep
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      seg_mem[JW'(joint_index_i)] <= {start_pos_i, start_vel_i, goal_pos_i, goal_vel_i};
    end
    if (rd_en) begin
      rd_q <= seg_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      seg_start_q <= '0;
      seg_dur_q   <= '0;
    end else begin
      if (load_ok) begin
        vld_q[JW'(joint_index_i)] <= 1'b1;
        seg_start_q               <= time_now_i;
        seg_dur_q                 <= run_time_i;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // ---------------------------------------------------------------------
  // shared multiplier: t*t, t2*t, then weight times stored value
  // ---------------------------------------------------------------------
  logic [QBITS:0]     t2_now;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_d;
  logic signed [31:0] mac_w;

  assign t2_now = prod_q[2*QBITS:QBITS];

  // unwritten joints read as zero
  always_comb begin
    case (k_q)
      3'd0:    mac_w = rd_q[127:96];  // start position
      3'd1:    mac_w = rd_q[95:64];   // start velocity
      3'd2:    mac_w = rd_q[31:0];    // goal velocity
      3'd3:    mac_w = rd_q[63:32];   // goal position
      default: mac_w = '0;
    endcase
    if (!rd_vld_q) mac_w = '0;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = 32'(t_q);
        mul_b = 32'(t_q);
      end
      ST_CUBE: begin
        mul_a = 32'(t2_now);
        mul_b = 32'(t_q);
      end
      ST_MAC: begin
        mul_a = (k_q < 3'd4) ? h_q[k_q[1:0]] : 32'sd0;
        mul_b = mac_w;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // ---------------------------------------------------------------------
  // hermite basis weights
  // ---------------------------------------------------------------------
  logic signed [33:0] tw, t2w, t3w;
  logic signed [33:0] h0w, h1w, h2w, h3w;

  assign tw  = signed'(34'(t_q));
  assign t2w = signed'(34'(t2_q));
  assign t3w = signed'(34'(t2_now));
  assign h0w = (34'sd1 <<< QBITS) - 34'sd3 * t2w + 34'sd2 * t3w;
  assign h1w = tw - 34'sd2 * t2w + t3w;
  assign h2w = t3w - t2w;
  assign h3w = 34'sd3 * t2w - 34'sd2 * t3w;

  // ---------------------------------------------------------------------
  // round to Q4.28 and saturate
  // ---------------------------------------------------------------------
  logic signed [63:0] acc_rnd;
  logic signed [33:0] pos_w;
  logic signed [31:0] pos_sat;

  assign acc_rnd = acc_q + (64'sd1 <<< (QBITS - 1));
  assign pos_w   = acc_rnd[63:QBITS];

  always_comb begin
    if (pos_w > 34'sh0_7FFF_FFFF) begin
      pos_sat = 32'sh7FFF_FFFF;
    end else if (pos_w < -34'sh0_8000_0000) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = pos_w[31:0];
    end
  end

  // ---------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        // clamped cases skip the divider
        if (t_full) begin
          t_q <= (QBITS+1)'(1) << QBITS;
        end else begin
          t_q <= '0;
        end
      end
      ST_DIV: begin
        if (div_done) t_q <= {1'b0, div_quot};
      end
      ST_SQ: begin
        prod_q <= prod_d;
      end
      ST_CUBE: begin
        t2_q   <= t2_now;
        prod_q <= prod_d;
      end
      ST_WGT: begin
        h_q[0] <= h0w[31:0];
        h_q[1] <= h1w[31:0];
        h_q[2] <= h2w[31:0];
        h_q[3] <= h3w[31:0];
      end
      ST_MAC: begin
        if (k_q < 3'd4) prod_q <= prod_d;
        if (k_q == 3'd1) begin
          acc_q <= prod_q;
        end else if (k_q != 3'd0) begin
          acc_q <= acc_q + prod_q;
        end
      end
      default: begin
      end
    endcase
  end

  // step counter within a joint and joint counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      jcnt_q <= '0;
    end else begin
      case (state_q)
        ST_WGT: begin
          k_q    <= '0;
          jcnt_q <= '0;
        end
        ST_MAC: begin
          k_q <= (k_q == 3'd4) ? 3'd0 : k_q + 3'd1;
        end
        ST_OUT: begin
          if (out_free && !jlast) jcnt_q <= jcnt_q + 1'b1;
        end
        default: begin
          k_q <= '0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_joint_q <= 3'(jcnt_q);
      position_q  <= pos_sat;
      last_q      <= jlast;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_joint_o = out_joint_q;
  assign position_o  = position_q;
  assign last_o      = last_q;

endmodule

>>> sim/cubic_hermite_joint_interpolator_test.sv
module cubic_hermite_joint_interpolator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import chji_pkg::*;

  localparam int JOINTS       = 7;
  localparam int DIR_ROWS     = 22;
  localparam int TOTAL_ITEMS  = 310;
  localparam int HOLD_CYCLES  = 600;   // long output hold-off, fills the block
  localparam int DRAIN_CYCLES = 100;   // quiet time after the drain, to catch stray results
  localparam int STALL_LIMIT  = 4000;  // cycles with no transaction on either side

  // request codes on req_type
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Q1.30 time and Q2.30 weights, Q4.28 positions
  localparam longint ONE_Q30  = 64'sd1 <<< QBITS;
  localparam longint HALF_Q30 = 64'sd1 <<< (QBITS - 1);
  localparam longint POS_MAX  = 64'sd2147483647;
  localparam longint POS_MIN  = -64'sd2147483648;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_e;

  // one input transaction; pinned rows carry a typed-in position per joint
  typedef struct {
    logic             req;
    logic [2:0]       joint;
    logic [31:0]      p0;
    logic [31:0]      v0;
    logic [31:0]      p1;
    logic [31:0]      v1;
    logic [31:0]      dur;
    logic [31:0]      now;
    bit               pinned;
    logic [0:6][31:0] pinned_pos;
  } seg_txn_t;

  // one result transaction
  typedef struct packed {
    logic [2:0]  joint;
    logic [31:0] pos;
    logic        last;
  } joint_pos_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               req_type_i    = REQ_TICK;
  logic [2:0]         joint_index_i = '0;
  logic signed [31:0] start_pos_i   = '0;
  logic signed [31:0] start_vel_i   = '0;
  logic signed [31:0] goal_pos_i    = '0;
  logic signed [31:0] goal_vel_i    = '0;
  logic [31:0]        run_time_i    = '0;
  logic [31:0]        time_now_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [2:0]         out_joint_o;
  logic signed [31:0] position_o;
  logic               last_o;

  cubic_hermite_joint_interpolator #(
    .NUM_JOINTS(JOINTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .joint_index_i(joint_index_i),
    .start_pos_i  (start_pos_i),
    .start_vel_i  (start_vel_i),
    .goal_pos_i   (goal_pos_i),
    .goal_vel_i   (goal_vel_i),
    .run_time_i   (run_time_i),
    .time_now_i   (time_now_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_joint_o  (out_joint_o),
    .position_o   (position_o),
    .last_o       (last_o)
  );

  // predictor copy of the segment store
  logic signed [31:0] seg_p0 [JOINTS] = '{default: '0};
  logic signed [31:0] seg_v0 [JOINTS] = '{default: '0};
  logic signed [31:0] seg_p1 [JOINTS] = '{default: '0};
  logic signed [31:0] seg_v1 [JOINTS] = '{default: '0};
  logic [31:0]        seg_begin = '0;
  logic [31:0]        seg_len   = '0;

  // positions still owed by the block, oldest first
  joint_pos_t joint_pos_due [$];

  int  failures    = 0;
  int  n_ticks     = 0;
  int  n_loads     = 0;
  int  n_ignored   = 0;
  int  n_checked   = 0;
  int  n_saturated = 0;
  int  burst_left  = 1;
  bit  random_phase = 1'b0;

  // directed rows: reset state, position extremes, time before, at and past the
  // segment, zero duration, a load to an absent joint, wrap of the time counter
  seg_txn_t dir_tab [DIR_ROWS] = '{
    // after reset: zero duration, every joint reads zero
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd0, 1'b1, '0},
    '{REQ_LOAD, 3'd0, 32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h0, 32'd1000, 32'd100,
      1'b0, '0},
    '{REQ_LOAD, 3'd1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
      32'd1000, 32'd100, 1'b0, '0},
    '{REQ_LOAD, 3'd6, 32'h10000000, 32'h0, 32'h20000000, 32'h0, 32'd1000, 32'd100,
      1'b0, '0},
    // absent joint: nothing may change, timing included
    '{REQ_LOAD, 3'd7, 32'hDEADBEEF, 32'h12345678, 32'hCAFEF00D, 32'h0F0F0F0F,
      32'd5, 32'd0, 1'b0, '0},
    // elapsed zero, then negative: start positions
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd100, 1'b1,
      {32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000000}},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd50, 1'b1,
      {32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000000}},
    // end of segment and far past it: goal positions
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd1100, 1'b1,
      {32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h20000000}},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'hFFFFFFFF, 1'b1,
      {32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h20000000}},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd600, 1'b0, '0},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd350, 1'b0, '0},
    // velocities that push the sum past the positive limit
    '{REQ_LOAD, 3'd2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
      32'd3, 32'hFFFFFFF0, 1'b0, '0},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'hFFFFFFF1, 1'b0, '0},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'hFFFFFFF2, 1'b0, '0},
    // and past the negative limit, longest duration
    '{REQ_LOAD, 3'd3, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
      32'hFFFFFFFF, 32'd0, 1'b0, '0},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'h80000000, 1'b0, '0},
    // zero duration: goal positions whatever the time
    '{REQ_LOAD, 3'd4, 32'h0, 32'h12345678, 32'h0ABCDEF0, 32'hFEDCBA98, 32'd0,
      32'd12345, 1'b0, '0},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd0, 1'b1,
      {32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0ABCDEF0,
       32'h0, 32'h20000000}},
    '{REQ_LOAD, 3'd5, 32'h00000001, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001,
      32'hFFFFFFFF, 32'd1, 1'b0, '0},
    // one microsecond early: start positions
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd0, 1'b1,
      {32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h0,
       32'h00000001, 32'h10000000}},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'hFFFFFFFE, 1'b0, '0},
    '{REQ_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'h7FFFFFFF, 1'b0, '0}
  };

  // normalized segment time, Q1.30
  function automatic longint norm_time(input logic [31:0] now);
    longint elapsed;
    longint span;
    elapsed = {32'd0, now};
    span    = {32'd0, seg_begin};
    elapsed = elapsed - span;
    span    = {32'd0, seg_len};
    if (span == 0) return ONE_Q30;
    if (elapsed <= 0) return 0;
    if (elapsed >= span) return ONE_Q30;
    return (elapsed <<< QBITS) / span;
  endfunction

  // loads update the store, ticks queue one position per joint
  function automatic void hermite_update(input seg_txn_t tx);
    longint     t, t2, t3, w0, w1, w2, w3;
    longint     a0, a1, a2, a3, acc, pos;
    joint_pos_t r;
    if (tx.req == REQ_LOAD) begin
      if (tx.joint < JOINTS) begin
        seg_p0[tx.joint] = tx.p0;
        seg_v0[tx.joint] = tx.v0;
        seg_p1[tx.joint] = tx.p1;
        seg_v1[tx.joint] = tx.v1;
        seg_len          = tx.dur;
        seg_begin        = tx.now;
      end
      return;
    end
    t  = norm_time(tx.now);
    t2 = (t * t) >>> QBITS;
    t3 = (t2 * t) >>> QBITS;
    // hermite basis weights
    w0 = ONE_Q30 - 3 * t2 + 2 * t3;
    w1 = t - 2 * t2 + t3;
    w2 = t3 - t2;
    w3 = 3 * t2 - 2 * t3;
    for (int j = 0; j < JOINTS; j++) begin
      a0  = seg_p0[j];
      a1  = seg_v0[j];
      a2  = seg_v1[j];
      a3  = seg_p1[j];
      acc = w0 * a0 + w1 * a1 + w2 * a2 + w3 * a3;
      // round to nearest, ties toward plus infinity
      pos = (acc + HALF_Q30) >>> QBITS;
      if (pos > POS_MAX || pos < POS_MIN) n_saturated++;
      if (pos > POS_MAX) pos = POS_MAX;
      if (pos < POS_MIN) pos = POS_MIN;
      r.joint = j[2:0];
      r.pos   = pos[31:0];
      r.last  = (j == JOINTS - 1);
      joint_pos_due.push_back(r);
    end
  endfunction

  // bookkeeping for an accepted input transaction
  function automatic void take(input seg_txn_t tx);
    joint_pos_t r;
    if (tx.req == REQ_LOAD) begin
      n_loads++;
      if (tx.joint >= JOINTS) n_ignored++;
    end else begin
      n_ticks++;
    end
    if (tx.req == REQ_TICK && tx.pinned) begin
      for (int j = 0; j < JOINTS; j++) begin
        r.joint = j[2:0];
        r.pos   = tx.pinned_pos[j];
        r.last  = (j == JOINTS - 1);
        joint_pos_due.push_back(r);
      end
    end else begin
      hermite_update(tx);
    end
  endfunction

  // position operand: wide random, small magnitude or an extreme
  function automatic logic [31:0] rand_q();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0, 1: rand_q = v;
      2:    rand_q = {{3{v[28]}}, v[28:0]};
      default: begin
        case ($urandom_range(0, 3))
          0:       rand_q = 32'h7FFFFFFF;
          1:       rand_q = 32'h80000000;
          2:       rand_q = 32'h0;
          default: rand_q = 32'hFFFFFFFF;
        endcase
      end
    endcase
  endfunction

  // drive at the falling edge, hold until taken, then apply bursts and gaps
  task automatic offer(input seg_txn_t tx);
    int gap;
    in_valid_i    = 1'b1;
    req_type_i    = tx.req;
    joint_index_i = tx.joint;
    start_pos_i   = tx.p0;
    start_vel_i   = tx.v0;
    goal_pos_i    = tx.p1;
    goal_vel_i    = tx.v1;
    run_time_i    = tx.dur;
    time_now_i    = tx.now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    take(tx);
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // a few loads sharing one segment, then ticks around its time window
  task automatic random_segment();
    seg_txn_t    tx;
    logic [31:0] base;
    logic [31:0] span;
    int          n_ld, n_tk;
    base = $urandom;
    case ($urandom_range(0, 5))
      0:       span = 32'd0;
      1:       span = $urandom;
      2:       span = $urandom_range(1, 4);
      default: span = $urandom_range(5, 200000);
    endcase
    n_ld = $urandom_range(1, JOINTS);
    n_tk = $urandom_range(1, 5);
    tx.pinned     = 1'b0;
    tx.pinned_pos = '0;
    repeat (n_ld) begin
      tx.req   = REQ_LOAD;
      tx.joint = 3'($urandom_range(0, JOINTS - 1));
      // now and then a broken load to the absent joint
      if ($urandom_range(0, 15) == 0) tx.joint = 3'd7;
      tx.p0  = rand_q();
      tx.v0  = rand_q();
      tx.p1  = rand_q();
      tx.v1  = rand_q();
      tx.dur = span;
      tx.now = base;
      offer(tx);
    end
    repeat (n_tk) begin
      tx.req   = REQ_TICK;
      tx.joint = 3'($urandom);
      tx.p0    = $urandom;
      tx.v0    = $urandom;
      tx.p1    = $urandom;
      tx.v1    = $urandom;
      tx.dur   = $urandom;
      case ($urandom_range(0, 7))
        0:       tx.now = base - $urandom_range(0, 1000);
        1:       tx.now = base + span + $urandom_range(0, 1000);
        2:       tx.now = $urandom;
        default: tx.now = base + $urandom_range(0, span);
      endcase
      offer(tx);
    end
  endtask

  // single transaction with every field random
  task automatic random_noise();
    seg_txn_t tx;
    tx.req        = 1'($urandom_range(0, 1));
    tx.joint      = 3'($urandom);
    tx.p0         = $urandom;
    tx.v0         = $urandom;
    tx.p1         = $urandom;
    tx.v1         = $urandom;
    tx.dur        = $urandom;
    tx.now        = $urandom;
    tx.pinned     = 1'b0;
    tx.pinned_pos = '0;
    offer(tx);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // output side: stall modes of random length, one long hold-off early in the
  // random part so the block backs up and stalls its input
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    bit       held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (random_phase && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_stall_i = 1'b1;
        end
      end else begin
        mode = rx_mode_e'($urandom_range(0, 3));
        span = $urandom_range(10, 300);
        repeat (span) begin
          @(negedge clk_i);
          case (mode)
            RX_OPEN:  out_stall_i = 1'b0;
            RX_LIGHT: out_stall_i = ($urandom_range(0, 3) == 0);
            RX_HALF:  out_stall_i = 1'($urandom_range(0, 1));
            default:  out_stall_i = ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  // compare every accepted result with the oldest owed position
  always @(posedge clk_i) begin : result_check
    joint_pos_t got;
    joint_pos_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_joint_o, position_o, last_o};
      n_checked++;
      if (joint_pos_due.size() == 0) begin
        failures++;
        $display("%0t: unexpected result joint %0d position %h last %b",
                 $time, got.joint, got.pos, got.last);
      end else begin
        want = joint_pos_due.pop_front();
        if (got !== want) begin
          failures++;
          $display("%0t: mismatch expected joint %0d position %h last %b,",
                   $time, want.joint, want.pos, want.last,
                   " got joint %0d position %h last %b",
                   got.joint, got.pos, got.last);
        end
      end
    end
  end

  // ends the run when neither side moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d positions still owed",
             $time, STALL_LIMIT, joint_pos_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) offer(dir_tab[i]);

    // random part, mostly well-formed segments
    random_phase = 1'b1;
    while (n_ticks + n_loads - n_ignored < TOTAL_ITEMS) begin
      if ($urandom_range(0, 4) == 0) random_noise();
      else random_segment();
    end
    in_valid_i = 1'b0;

    // drain, then watch for stray results
    while (joint_pos_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d ticks and %0d loads (%0d to an absent joint)",
             n_ticks, n_loads, n_ignored, " through stalls and a long hold-off");
    $display("compared %0d joint positions, %0d of them saturated", n_checked, n_saturated);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
